/* sv/subset_degree_tracker_defines.svh */
// Assertion macros shared by the subset degree tracker RTL.
// Expects a clock named aclk and an active-low reset named aresetn in scope.
`ifndef SUBSET_DEGREE_TRACKER_DEFINES_SVH
`define SUBSET_DEGREE_TRACKER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define SDT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SDT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/sdt_pkg.sv */
// Shared constants, operation codes and helper functions for the subset degree tracker.
// No dependencies; imported by sdt_ram and subset_degree_tracker.
package sdt_pkg;

    localparam int DEF_MAX_VERTICES = 64;

    // Field widths fixed by the stream format
    localparam int OP_W      = 2;
    localparam int VX_W      = 6;
    localparam int ROW_W     = 64;
    localparam int CNT_W     = 7;
    localparam int ENTRY_W   = VX_W + 1;
    localparam int EDGE_W    = 12;
    localparam int SUM_W     = EDGE_W + 1;
    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 32;

    localparam logic [CNT_W-1:0] VCOUNT_RESET = 7'd64;
    localparam logic [CNT_W-1:0] DEG_MAX      = 7'd64;

    // Operation codes carried on s_tuser
    localparam logic [OP_W-1:0] OP_LOAD_ROW   = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_ENTRY = 2'd1;
    localparam logic [OP_W-1:0] OP_SWAP       = 2'd2;
    localparam logic [OP_W-1:0] OP_QUERY      = 2'd3;

    // A list entry counts when marked valid and its vertex is in use
    function automatic logic entry_usable(input logic [ENTRY_W-1:0] e,
                                          input logic [CNT_W-1:0]   eff);
        return e[ENTRY_W-1] && (CNT_W'(e[VX_W-1:0]) < eff);
    endfunction

    // Apply one swap step to a degree: drop the old neighbor, add the new one
    function automatic logic [CNT_W-1:0] deg_step(input logic [CNT_W-1:0] d,
                                                  input logic             drop,
                                                  input logic             add);
        logic [CNT_W-1:0] r;
        r = d;
        if (drop && !add) begin
            r = (d == '0) ? '0 : d - CNT_W'(1);
        end else if (add && !drop) begin
            r = (d >= DEG_MAX) ? DEG_MAX : d + CNT_W'(1);
        end
        return r;
    endfunction

endpackage

/* sv/sdt_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on sdt_pkg for default sizes.
module sdt_ram
    import sdt_pkg::*;
#(
    parameter int WIDTH = ROW_W,
    parameter int DEPTH = DEF_MAX_VERTICES
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/subset_degree_tracker.sv */
// Subset degree tracker: holds an adjacency matrix, a subset list and per-vertex degrees into
// the subset. One item is worked on at a time; s_tready is high only while the sequencer is
// idle, and a finished result sits in the output register so the next item can be taken
// before it is read. A swap updates one degree per cycle for each vertex below eff (eff =
// min(vertex_count, MAX_VERTICES)) through the degree table's single read and write port,
// then sums the edge count over the list one entry per cycle. An entry marked last
// triggers a full recompute of every vertex's degree: each vertex's row is held at the
// adjacency memory output while the subset list memory streams one entry per cycle into a
// single accumulator. Depends on sdt_pkg, sdt_ram.
`include "subset_degree_tracker_defines.svh"

module subset_degree_tracker
    import sdt_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration: vertex_count
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CNT_W-1:0]     cfg_data,
    // Input items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // tdata: row_index[5:0], row_bits[69:6], position[75:70], vertex[81:76],
    //        vertex_valid[82], zero padding[87:83]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // tuser: op[1:0]
    input  logic [OP_W-1:0]      s_tuser,
    // tlast: last_entry
    input  logic                 s_tlast,
    // Result items
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // tdata: edge_count[11:0], degree[18:12], subset_size[25:19], zero padding[31:26]
    output logic [M_TDATA_W-1:0] m_tdata,
    // tuser: error[0]
    output logic                 m_tuser
);

    localparam int IW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam logic [CNT_W-1:0] NV       = CNT_W'(MAX_VERTICES);
    localparam logic [IW-1:0]    LAST_IDX = IW'(MAX_VERTICES - 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_QUERY  = 4'd1;
    localparam logic [3:0] S_R_SCAN = 4'd2;
    localparam logic [3:0] S_W_CHK  = 4'd3;
    localparam logic [3:0] S_W_ROWA = 4'd4;
    localparam logic [3:0] S_W_SCAN = 4'd5;
    localparam logic [3:0] S_E_SCAN = 4'd6;
    localparam logic [3:0] S_DONE   = 4'd7;

    // Input field split
    logic [VX_W-1:0]  in_row_index;
    logic [ROW_W-1:0] in_row_bits;
    logic [VX_W-1:0]  in_position;
    logic [VX_W-1:0]  in_vertex;
    logic             in_vertex_valid;

    assign in_row_index    = s_tdata[5:0];
    assign in_row_bits     = s_tdata[69:6];
    assign in_position     = s_tdata[75:70];
    assign in_vertex       = s_tdata[81:76];
    assign in_vertex_valid = s_tdata[82];

    // Control state
    logic [3:0]              state_reg, state_next;
    logic [CNT_W-1:0]        vcount_reg, vcount_next;
    logic [CNT_W-1:0]        size_reg, size_next;
    logic [EDGE_W-1:0]       edges_reg, edges_next;
    logic [MAX_VERTICES-1:0] deg_valid_reg, deg_valid_next;
    logic                    p1_reg, p1_next;
    logic                    p2_reg, p2_next;
    logic                    m_tvalid_reg, m_tvalid_next;

    // Working and payload registers
    logic [OP_W-1:0]      op_reg, op_next;
    logic [VX_W-1:0]      pos_reg, pos_next;
    logic [ENTRY_W-1:0]   new_entry_reg, new_entry_next;
    logic                 vq_ok_reg, vq_ok_next;
    logic [IW-1:0]        i_reg, i_next;
    logic [CW-1:0]        k_reg, k_next;
    logic [IW-1:0]        wa_reg, wa_next;
    logic [CNT_W-1:0]     d_reg, d_next;
    logic [SUM_W-1:0]     total_reg, total_next;
    logic [ROW_W-1:0]     row_a_reg, row_a_next;
    logic                 dval_reg;
    logic [CNT_W-1:0]     res_degree_reg, res_degree_next;
    logic                 res_error_reg, res_error_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                 m_tuser_reg, m_tuser_next;

    // Memory ports
    logic                 adj_we;
    logic [IW-1:0]        adj_waddr, adj_raddr;
    logic [ROW_W-1:0]     adj_rdata;
    logic                 sub_we;
    logic [IW-1:0]        sub_waddr, sub_raddr;
    logic [ENTRY_W-1:0]   sub_wdata, sub_rdata;
    logic                 deg_we;
    logic [IW-1:0]        deg_waddr, deg_raddr;
    logic [CNT_W-1:0]     deg_wdata, deg_rdata;

    logic [CNT_W-1:0]     eff;
    logic [CNT_W-1:0]     deg_rd;
    logic                 accept;
    logic                 k_lt_size;
    logic                 k_lt_eff;
    logic                 swap_ok;
    logic [VX_W-1:0]      wa_col;

    assign eff       = (vcount_reg < NV) ? vcount_reg : NV;
    assign deg_rd    = dval_reg ? deg_rdata : '0;
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign k_lt_size = CNT_W'(k_reg) < size_reg;
    assign k_lt_eff  = CNT_W'(k_reg) < eff;
    assign wa_col    = VX_W'(wa_reg);
    assign swap_ok   = (CNT_W'(pos_reg) < size_reg) && entry_usable(sub_rdata, eff)
                       && entry_usable(new_entry_reg, eff);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    sdt_ram #(.WIDTH(ROW_W), .DEPTH(MAX_VERTICES)) u_adj_ram (
        .aclk  (aclk),
        .we    (adj_we),
        .waddr (adj_waddr),
        .wdata (in_row_bits),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    sdt_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_VERTICES)) u_sub_ram (
        .aclk  (aclk),
        .we    (sub_we),
        .waddr (sub_waddr),
        .wdata (sub_wdata),
        .raddr (sub_raddr),
        .rdata (sub_rdata)
    );

    sdt_ram #(.WIDTH(CNT_W), .DEPTH(MAX_VERTICES)) u_deg_ram (
        .aclk  (aclk),
        .we    (deg_we),
        .waddr (deg_waddr),
        .wdata (deg_wdata),
        .raddr (deg_raddr),
        .rdata (deg_rdata)
    );

    // Sequencer and datapath next-state logic
    always_comb begin
        state_next      = state_reg;
        vcount_next     = vcount_reg;
        size_next       = size_reg;
        edges_next      = edges_reg;
        deg_valid_next  = deg_valid_reg;
        p1_next         = p1_reg;
        p2_next         = p2_reg;
        m_tvalid_next   = m_tvalid_reg;
        op_next         = op_reg;
        pos_next        = pos_reg;
        new_entry_next  = new_entry_reg;
        vq_ok_next      = vq_ok_reg;
        i_next          = i_reg;
        k_next          = k_reg;
        wa_next         = wa_reg;
        d_next          = d_reg;
        total_next      = total_reg;
        row_a_next      = row_a_reg;
        res_degree_next = res_degree_reg;
        res_error_next  = res_error_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;

        adj_we    = 1'b0;
        adj_waddr = in_row_index[IW-1:0];
        adj_raddr = i_reg;
        sub_we    = 1'b0;
        sub_waddr = in_position[IW-1:0];
        sub_wdata = {in_vertex_valid, in_vertex};
        sub_raddr = k_reg[IW-1:0];
        deg_we    = 1'b0;
        deg_waddr = i_reg;
        deg_wdata = d_reg;
        deg_raddr = k_reg[IW-1:0];

        // Take a configuration write
        if (cfg_valid) begin
            vcount_next = cfg_data;
        end

        // Drop the output once transferred
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                deg_raddr = in_vertex[IW-1:0];
                sub_raddr = in_position[IW-1:0];
                if (accept) begin
                    op_next         = s_tuser;
                    pos_next        = in_position;
                    new_entry_next  = {in_vertex_valid, in_vertex};
                    vq_ok_next      = CNT_W'(in_vertex) < NV;
                    res_degree_next = '0;
                    res_error_next  = 1'b0;
                    state_next      = S_DONE;
                    unique case (s_tuser)
                        OP_LOAD_ROW: begin
                            adj_we = CNT_W'(in_row_index) < NV;
                        end
                        OP_LOAD_ENTRY: begin
                            if (CNT_W'(in_position) < NV) begin
                                sub_we = 1'b1;
                                if (s_tlast) begin
                                    size_next  = CNT_W'(in_position) + CNT_W'(1);
                                    i_next     = '0;
                                    k_next     = '0;
                                    d_next     = '0;
                                    p1_next    = 1'b0;
                                    state_next = S_R_SCAN;
                                end
                            end
                        end
                        OP_SWAP: begin
                            state_next = S_W_CHK;
                        end
                        OP_QUERY: begin
                            state_next = S_QUERY;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_QUERY: begin
                res_degree_next = vq_ok_reg ? deg_rd : '0;
                state_next      = S_DONE;
            end

            // Recompute: stream list entries against the row of vertex i
            S_R_SCAN: begin
                if (p1_reg && entry_usable(sub_rdata, eff)) begin
                    d_next = d_reg + CNT_W'(adj_rdata[sub_rdata[VX_W-1:0]]);
                end
                if (k_lt_size) begin
                    p1_next = 1'b1;
                    k_next  = k_reg + CW'(1);
                end else begin
                    p1_next = 1'b0;
                end
                if (!p1_reg && !k_lt_size) begin
                    deg_we    = 1'b1;
                    deg_wdata = (CNT_W'(i_reg) < eff) ? d_reg : '0;
                    deg_valid_next[i_reg] = 1'b1;
                    k_next    = '0;
                    d_next    = '0;
                    if (i_reg == LAST_IDX) begin
                        total_next = '0;
                        p2_next    = 1'b0;
                        state_next = S_E_SCAN;
                    end else begin
                        i_next = i_reg + IW'(1);
                    end
                end
            end

            // Swap: check the old entry, then fetch the old vertex's row
            S_W_CHK: begin
                if (swap_ok) begin
                    sub_we     = 1'b1;
                    sub_waddr  = pos_reg[IW-1:0];
                    sub_wdata  = new_entry_reg;
                    adj_raddr  = sub_rdata[IW-1:0];
                    state_next = S_W_ROWA;
                end else begin
                    res_error_next = 1'b1;
                    state_next     = S_DONE;
                end
            end

            // Hold the old row; the new vertex's row stays at the memory output
            S_W_ROWA: begin
                adj_raddr  = new_entry_reg[IW-1:0];
                row_a_next = adj_rdata;
                k_next     = '0;
                p1_next    = 1'b0;
                state_next = S_W_SCAN;
            end

            // Swap: update one degree per cycle, read j while writing j-1
            S_W_SCAN: begin
                adj_raddr = new_entry_reg[IW-1:0];
                if (k_lt_eff) begin
                    p1_next = 1'b1;
                    wa_next = k_reg[IW-1:0];
                    k_next  = k_reg + CW'(1);
                end else begin
                    p1_next = 1'b0;
                end
                if (p1_reg) begin
                    deg_we    = 1'b1;
                    deg_waddr = wa_reg;
                    deg_wdata = deg_step(deg_rd, row_a_reg[wa_col], adj_rdata[wa_col]);
                    deg_valid_next[wa_reg] = 1'b1;
                end
                if (!p1_reg && !k_lt_eff) begin
                    k_next     = '0;
                    total_next = '0;
                    p2_next    = 1'b0;
                    state_next = S_E_SCAN;
                end
            end

            // Edge count: list entry, then its degree, then accumulate
            S_E_SCAN: begin
                deg_raddr = sub_rdata[IW-1:0];
                if (k_lt_size) begin
                    p1_next = 1'b1;
                    k_next  = k_reg + CW'(1);
                end else begin
                    p1_next = 1'b0;
                end
                p2_next = p1_reg && entry_usable(sub_rdata, eff);
                if (p2_reg) begin
                    total_next = total_reg + SUM_W'(deg_rd);
                end
                if (!k_lt_size && !p1_reg && !p2_reg) begin
                    edges_next = total_reg[SUM_W-1:1];
                    state_next = S_DONE;
                end
            end

            // Load the output register once it is free
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {(M_TDATA_W - EDGE_W - 2 * CNT_W)'(0),
                                     size_reg, res_degree_reg, edges_reg};
                    m_tuser_next  = res_error_reg;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            vcount_reg    <= VCOUNT_RESET;
            size_reg      <= '0;
            edges_reg     <= '0;
            deg_valid_reg <= '0;
            p1_reg        <= 1'b0;
            p2_reg        <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            vcount_reg    <= vcount_next;
            size_reg      <= size_next;
            edges_reg     <= edges_next;
            deg_valid_reg <= deg_valid_next;
            p1_reg        <= p1_next;
            p2_reg        <= p2_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        pos_reg        <= pos_next;
        new_entry_reg  <= new_entry_next;
        vq_ok_reg      <= vq_ok_next;
        i_reg          <= i_next;
        k_reg          <= k_next;
        wa_reg         <= wa_next;
        d_reg          <= d_next;
        total_reg      <= total_next;
        row_a_reg      <= row_a_next;
        dval_reg       <= deg_valid_reg[deg_raddr];
        res_degree_reg <= res_degree_next;
        res_error_reg  <= res_error_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    `SDT_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "second item taken while busy")
    `SDT_ASSERT_SAME(a_size_bound, 1'b1, size_reg <= NV, "subset size beyond vertex capacity")
    `SDT_ASSERT_SAME(a_err_swap, state_reg == S_DONE && res_error_reg,
                     op_reg == OP_SWAP, "error on non-swap item")
    `SDT_ASSERT_SAME(a_swap_range, state_reg == S_W_SCAN && p1_reg,
                     CNT_W'(wa_reg) < eff, "swap wrote degree out of range")

endmodule
